>>> hdl/rrhp_pkg.sv
// ----------------------------------------------------------------------------
// rrhp_pkg
// Types and constants shared by the request header parser modules.
// ----------------------------------------------------------------------------
package rrhp_pkg;

  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;

  // Verdict error codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_STAR   = 3'd1;
  localparam logic [2:0] ERR_NO_DOLLAR = 3'd2;
  localparam logic [2:0] ERR_BAD_NUM   = 3'd3;
  localparam logic [2:0] ERR_NO_DELIM  = 3'd4;
  localparam logic [2:0] ERR_END_DELIM = 3'd5;

  // Magnitude limits for a 32-bit signed field, at the width of the
  // multiply-by-ten sum.
  localparam int          ACC_W       = 36;
  localparam logic [35:0] LIMIT_POS   = 36'h0_7FFF_FFFF;
  localparam logic [35:0] LIMIT_NEG   = 36'h0_8000_0000;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  localparam int OUT_DATA_W = 112;

  typedef enum logic [2:0] {
    PH_ARR_PREFIX,
    PH_ARR_FIELD,
    PH_CMD_PREFIX,
    PH_CMD_FIELD,
    PH_COMMAND,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    ST_START,
    ST_SIGN,
    ST_DIGITS,
    ST_TRAIL
  } stage_t;

  // Everything one input byte produces: an optional command byte and an
  // optional verdict, in that order.
  typedef struct packed {
    logic        has_cmd;
    logic [7:0]  cmd_byte;
    logic        has_verdict;
    logic        success;
    logic [2:0]  fault_code;
    logic [31:0] array_length;
    logic [31:0] command_length;
    logic [30:0] taken;
  } entry_t;

endpackage

>>> hdl/rrhp_front.sv
// ----------------------------------------------------------------------------
// rrhp_front
// Byte parser: walks the header grammar and emits one queue entry for each
// byte that produces output.
// ----------------------------------------------------------------------------
module rrhp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       data_byte,
  input  logic             end_of_message,
  output logic             push,
  output rrhp_pkg::entry_t entry
);

  rrhp_pkg::phase_t phase, phase_upd, phase_next;
  rrhp_pkg::stage_t stage, stage_upd;
  logic        negative, negative_upd;
  logic [31:0] magnitude, magnitude_upd;
  logic        bad, bad_upd;
  logic        saw_cr, saw_cr_upd;
  logic [31:0] array_count, array_count_upd;
  logic [31:0] command_count, command_count_upd;
  logic [30:0] command_taken, command_taken_upd;
  logic [2:0]  error_kind, error_kind_upd;

  logic        is_digit;
  logic [rrhp_pkg::ACC_W-1:0] acc;
  logic        over;
  logic        delim;
  logic        cmd_emit;
  logic [31:0] field_value;

  assign is_digit = (data_byte >= rrhp_pkg::CHAR_ZERO) && (data_byte <= rrhp_pkg::CHAR_NINE);
  // magnitude * 10 + digit as two shifted adds.
  assign acc = {1'b0, magnitude, 3'b000} + {3'b000, magnitude, 1'b0}
             + {32'd0, 4'(data_byte - rrhp_pkg::CHAR_ZERO)};
  assign over = acc > (negative ? rrhp_pkg::LIMIT_NEG : rrhp_pkg::LIMIT_POS);
  assign delim = saw_cr && (data_byte == rrhp_pkg::CHAR_LF);
  assign field_value = negative ? (32'd0 - magnitude) : magnitude;
  assign cmd_emit = (phase == rrhp_pkg::PH_COMMAND) && !command_count[31]
                  && ({1'b0, command_taken} < command_count);

  // Next phase.
  always_comb begin
    phase_upd = phase;
    unique case (phase)
      rrhp_pkg::PH_ARR_PREFIX, rrhp_pkg::PH_CMD_PREFIX: begin
        if (data_byte != ((phase == rrhp_pkg::PH_ARR_PREFIX) ?
                          rrhp_pkg::CHAR_STAR : rrhp_pkg::CHAR_DOLLAR)) begin
          phase_upd = rrhp_pkg::PH_ERROR;
        end else if (end_of_message) begin
          phase_upd = rrhp_pkg::PH_ERROR;
        end else if (phase == rrhp_pkg::PH_ARR_PREFIX) begin
          phase_upd = rrhp_pkg::PH_ARR_FIELD;
        end else begin
          phase_upd = rrhp_pkg::PH_CMD_FIELD;
        end
      end
      rrhp_pkg::PH_ARR_FIELD, rrhp_pkg::PH_CMD_FIELD: begin
        if (delim) begin
          if (bad || end_of_message) begin
            phase_upd = rrhp_pkg::PH_ERROR;
          end else if (phase == rrhp_pkg::PH_ARR_FIELD) begin
            phase_upd = rrhp_pkg::PH_CMD_PREFIX;
          end else begin
            phase_upd = rrhp_pkg::PH_COMMAND;
          end
        end else if (end_of_message) begin
          phase_upd = rrhp_pkg::PH_ERROR;
        end
      end
      rrhp_pkg::PH_COMMAND: phase_upd = rrhp_pkg::PH_COMMAND;
      default: phase_upd = rrhp_pkg::PH_ERROR;
    endcase
    phase_next = end_of_message ? rrhp_pkg::PH_ARR_PREFIX : phase_upd;
  end

  // Field and count updates.
  always_comb begin
    stage_upd         = stage;
    negative_upd      = negative;
    magnitude_upd     = magnitude;
    bad_upd           = bad;
    saw_cr_upd        = saw_cr;
    array_count_upd   = array_count;
    command_count_upd = command_count;
    command_taken_upd = command_taken;
    error_kind_upd    = error_kind;
    case (phase)
      rrhp_pkg::PH_ARR_PREFIX, rrhp_pkg::PH_CMD_PREFIX: begin
        if (data_byte != ((phase == rrhp_pkg::PH_ARR_PREFIX) ?
                          rrhp_pkg::CHAR_STAR : rrhp_pkg::CHAR_DOLLAR)) begin
          error_kind_upd = (phase == rrhp_pkg::PH_ARR_PREFIX) ?
                           rrhp_pkg::ERR_NO_STAR : rrhp_pkg::ERR_NO_DOLLAR;
        end else begin
          stage_upd    = rrhp_pkg::ST_START;
          negative_upd = 1'b0;
          magnitude_upd = 32'd0;
          bad_upd      = 1'b0;
          saw_cr_upd   = 1'b0;
          if (end_of_message) begin
            error_kind_upd = rrhp_pkg::ERR_NO_DELIM;
          end
        end
      end
      rrhp_pkg::PH_ARR_FIELD, rrhp_pkg::PH_CMD_FIELD: begin
        if (delim) begin
          if (bad) begin
            error_kind_upd = rrhp_pkg::ERR_BAD_NUM;
          end else if (end_of_message) begin
            error_kind_upd = rrhp_pkg::ERR_END_DELIM;
          end else if (phase == rrhp_pkg::PH_ARR_FIELD) begin
            array_count_upd = field_value;
          end else begin
            command_count_upd = field_value;
            command_taken_upd = 31'd0;
          end
          stage_upd     = rrhp_pkg::ST_START;
          negative_upd  = 1'b0;
          magnitude_upd = 32'd0;
          bad_upd       = 1'b0;
          saw_cr_upd    = 1'b0;
        end else begin
          case (stage)
            rrhp_pkg::ST_START, rrhp_pkg::ST_SIGN: begin
              if ((stage == rrhp_pkg::ST_START) && (data_byte == rrhp_pkg::CHAR_MINUS)) begin
                negative_upd = 1'b1;
                stage_upd    = rrhp_pkg::ST_SIGN;
              end else if (is_digit) begin
                stage_upd = rrhp_pkg::ST_DIGITS;
                if (!bad) begin
                  if (over) bad_upd = 1'b1;
                  else      magnitude_upd = acc[31:0];
                end
              end else begin
                bad_upd   = 1'b1;
                stage_upd = rrhp_pkg::ST_TRAIL;
              end
            end
            rrhp_pkg::ST_DIGITS: begin
              if (is_digit) begin
                if (!bad) begin
                  if (over) bad_upd = 1'b1;
                  else      magnitude_upd = acc[31:0];
                end
              end else begin
                stage_upd = rrhp_pkg::ST_TRAIL;
              end
            end
            default: stage_upd = stage;
          endcase
          saw_cr_upd = (data_byte == rrhp_pkg::CHAR_CR);
          if (end_of_message) begin
            error_kind_upd = rrhp_pkg::ERR_NO_DELIM;
          end
        end
      end
      rrhp_pkg::PH_COMMAND: begin
        if (cmd_emit) begin
          command_taken_upd = command_taken + 31'd1;
        end
      end
      default: error_kind_upd = error_kind;
    endcase
  end

  // Entry for the queue.
  always_comb begin
    entry = '0;
    entry.has_cmd     = cmd_emit;
    entry.cmd_byte    = cmd_emit ? data_byte : 8'd0;
    entry.has_verdict = end_of_message;
    if (end_of_message) begin
      if (phase_upd == rrhp_pkg::PH_COMMAND) begin
        entry.success        = 1'b1;
        entry.fault_code     = rrhp_pkg::ERR_NONE;
        entry.array_length   = array_count_upd;
        entry.command_length = command_count_upd;
        entry.taken          = command_taken_upd;
      end else begin
        entry.fault_code = (error_kind_upd == rrhp_pkg::ERR_NONE) ?
                           rrhp_pkg::ERR_NO_DELIM : error_kind_upd;
      end
    end
    push = take && (cmd_emit || end_of_message);
  end

  always_ff @(posedge clk) begin
    if (rst || (take && end_of_message)) begin
      phase         <= rrhp_pkg::PH_ARR_PREFIX;
      stage         <= rrhp_pkg::ST_START;
      negative      <= 1'b0;
      magnitude     <= 32'd0;
      bad           <= 1'b0;
      saw_cr        <= 1'b0;
      array_count   <= 32'd0;
      command_count <= 32'd0;
      command_taken <= 31'd0;
      error_kind    <= rrhp_pkg::ERR_NONE;
    end else if (take) begin
      phase         <= phase_next;
      stage         <= stage_upd;
      negative      <= negative_upd;
      magnitude     <= magnitude_upd;
      bad           <= bad_upd;
      saw_cr        <= saw_cr_upd;
      array_count   <= array_count_upd;
      command_count <= command_count_upd;
      command_taken <= command_taken_upd;
      error_kind    <= error_kind_upd;
    end
  end

endmodule

>>> hdl/rrhp_queue.sv
// ----------------------------------------------------------------------------
// rrhp_queue
// Short first-in first-out queue of parser entries between front and back.
// ----------------------------------------------------------------------------
module rrhp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rrhp_pkg::entry_t wr_entry,
  output logic             full,
  input  logic             pop,
  output rrhp_pkg::entry_t rd_entry,
  output logic             empty
);

  rrhp_pkg::entry_t slots [rrhp_pkg::QDEPTH];
  logic [rrhp_pkg::QPTR_W-1:0] wr_ptr;
  logic [rrhp_pkg::QPTR_W-1:0] rd_ptr;
  logic [rrhp_pkg::QCNT_W-1:0] count;

  assign full     = (count == rrhp_pkg::QCNT_W'(rrhp_pkg::QDEPTH));
  assign empty    = (count == '0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= rrhp_pkg::QCNT_W'(rrhp_pkg::QDEPTH))
    else $error("queue count beyond depth");

endmodule

>>> hdl/rrhp_back.sv
// ----------------------------------------------------------------------------
// rrhp_back
// Result sequencer: turns each queue entry into its command byte beat, its
// verdict beat or both, in that order, on the output stream.
// ----------------------------------------------------------------------------
module rrhp_back (
  input  logic                            clk,
  input  logic                            rst,
  input  rrhp_pkg::entry_t                head,
  input  logic                            empty,
  output logic                            pop,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [rrhp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [0:0]                      m_axis_tuser,
  output logic                            m_axis_tlast
);

  logic cmd_done;
  logic show_cmd;
  logic beat;

  assign show_cmd      = head.has_cmd && !cmd_done;
  assign m_axis_tvalid = !empty;
  assign beat          = m_axis_tvalid && m_axis_tready;
  assign pop           = beat && (!show_cmd || !head.has_verdict);
  assign m_axis_tuser  = show_cmd ? 1'b0 : 1'b1;
  assign m_axis_tlast  = show_cmd ? !head.has_verdict : 1'b1;

  always_comb begin
    if (show_cmd) begin
      m_axis_tdata = {104'd0, head.cmd_byte};
    end else begin
      m_axis_tdata = {5'd0, head.taken, head.command_length, head.array_length,
                      head.fault_code, head.success, 8'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_done <= 1'b0;
    end else if (beat) begin
      cmd_done <= show_cmd && head.has_verdict;
    end
  end

endmodule

>>> hdl/resp_request_header_parser.sv
// ----------------------------------------------------------------------------
// resp_request_header_parser
// Streaming parser for the array and bulk string header of a request.
// ----------------------------------------------------------------------------
// Request bytes enter one per beat on the slave stream, with tlast on the
// final byte. The parser checks for '*', a signed decimal array length and
// CR LF, then '$', a signed decimal command length and CR LF, and then
// forwards up to that many command bytes as result beats with tuser = 0.
// On the final byte it adds a verdict beat (tuser = 1) that carries success
// or an error code and, on success, both lengths and the number of command
// bytes forwarded. A request cut short inside the command is a success.
// The parser takes one byte every cycle; its state update, including the
// shift-and-add multiply by ten, is combinational and registered on each
// accepted byte. Its results go through a four-entry queue to the output
// sequencer, which sends one beat a cycle while tready is high, so a final
// command byte and its verdict leave as two beats. The input stalls only
// while that queue is full, and the parser restarts after each final byte.
// ----------------------------------------------------------------------------
module resp_request_header_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: [7:0] data_byte
  input  logic [7:0]                      s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: [7:0] command_byte, [8] success, [11:9] fault code,
  // [43:12] array_length, [75:44] command_length,
  // [106:76] command_bytes_received, [111:107] zero
  output logic [rrhp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: [0] kind (0 command byte, 1 verdict)
  output logic [0:0]                      m_axis_tuser,
  output logic                            m_axis_tlast
);

  logic             take;
  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  rrhp_pkg::entry_t wr_entry;
  rrhp_pkg::entry_t head;

  // The front only needs queue room; it does not wait for the output side.
  assign s_axis_tready = !full;
  assign take          = s_axis_tvalid && s_axis_tready;

  rrhp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .data_byte      (s_axis_tdata),
    .end_of_message (s_axis_tlast),
    .push           (push),
    .entry          (wr_entry)
  );

  rrhp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (full),
    .pop      (pop),
    .rd_entry (head),
    .empty    (empty)
  );

  rrhp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the request header parser.
// ----------------------------------------------------------------------------
// Requests are sent one byte per beat, with tlast on the final byte. The
// testbench keeps its own model of the parser. It updates that model on
// every accepted byte and queues the result beats that the byte must cause.
// A checker compares every result beat, field by field, against the oldest
// queued beat. The stimulus starts with hand-written requests that cover
// each verdict and each corner of the length fields. It then sends random
// well-formed requests, runs a stretch with no idling, and ends with
// corrupted requests and noise. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;

  // Cycles without any accepted beat before the run is declared hung.
  localparam int IDLE_LIMIT    = 1000;
  // Cycles allowed after the last result so that a stray beat shows up.
  localparam int SETTLE_CYCLES = 20;

  // One result beat as the parser must produce it.
  typedef struct packed {
    logic        kind;
    logic [7:0]  cbyte;
    logic        success;
    logic [2:0]  err;
    logic [31:0] alen;
    logic [31:0] clen;
    logic [30:0] taken;
    logic        last;
  } parse_result_t;

  logic                            clk           = 1'b0;
  logic                            rst           = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata  = 8'h00;
  logic                            s_axis_tlast  = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [rrhp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]                      m_axis_tuser;
  logic                            m_axis_tlast;

  // Result beats still owed by the parser, oldest first.
  parse_result_t due_results[$];
  // Bytes of the request that is being put together.
  logic [7:0]    request_bytes[$];

  int   mismatches = 0;
  int   bytes_sent = 0;
  int   quiet      = 0;
  // When set, neither side idles.
  logic steady     = 1'b0;

  // Model state of the parser.
  rrhp_pkg::phase_t cur_phase;
  rrhp_pkg::stage_t cur_stage;
  logic        fld_neg;
  logic        fld_bad;
  logic        fld_cr;
  logic [31:0] fld_mag;
  logic [31:0] arr_len;
  logic [31:0] cmd_len;
  logic [30:0] cmd_sent;
  logic [2:0]  err_code;

  resp_request_header_parser uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------

  function automatic void reset_field();
    cur_stage = rrhp_pkg::ST_START;
    fld_neg   = 1'b0;
    fld_mag   = 32'd0;
    fld_bad   = 1'b0;
    fld_cr    = 1'b0;
  endfunction

  function automatic void reset_request();
    cur_phase = rrhp_pkg::PH_ARR_PREFIX;
    reset_field();
    arr_len  = 32'd0;
    cmd_len  = 32'd0;
    cmd_sent = 31'd0;
    err_code = rrhp_pkg::ERR_NONE;
  endfunction

  // Multiply by ten and add; once out of range the field stays bad and the
  // magnitude is frozen. A negative field may reach one more than a positive.
  function automatic void take_digit(input logic [7:0] b);
    logic [63:0] sum;
    sum = {32'd0, fld_mag} * 64'd10 + {56'd0, 8'(b - rrhp_pkg::CHAR_ZERO)};
    if (!fld_bad) begin
      if (sum > (fld_neg ? 64'd2147483648 : 64'd2147483647))
        fld_bad = 1'b1;
      else
        fld_mag = sum[31:0];
    end
  endfunction

  function automatic void field_byte(input logic [7:0] b);
    logic digit;
    digit = (b >= rrhp_pkg::CHAR_ZERO) && (b <= rrhp_pkg::CHAR_NINE);
    case (cur_stage)
      rrhp_pkg::ST_START: begin
        if (b == rrhp_pkg::CHAR_MINUS) begin
          fld_neg   = 1'b1;
          cur_stage = rrhp_pkg::ST_SIGN;
        end else if (digit) begin
          take_digit(b);
          cur_stage = rrhp_pkg::ST_DIGITS;
        end else begin
          fld_bad   = 1'b1;
          cur_stage = rrhp_pkg::ST_TRAIL;
        end
      end
      rrhp_pkg::ST_SIGN: begin
        if (digit) begin
          take_digit(b);
          cur_stage = rrhp_pkg::ST_DIGITS;
        end else begin
          fld_bad   = 1'b1;
          cur_stage = rrhp_pkg::ST_TRAIL;
        end
      end
      rrhp_pkg::ST_DIGITS: begin
        if (digit)
          take_digit(b);
        else
          cur_stage = rrhp_pkg::ST_TRAIL;
      end
      default: ;
    endcase
  endfunction

  // Advances the model by one accepted byte and queues the beats it causes:
  // a command byte, a verdict on the final byte, or both in that order.
  function automatic void parse_request_byte(input logic [7:0] b, input logic eom);
    logic [7:0]    prefix;
    logic [31:0]   value;
    parse_result_t r;
    case (cur_phase)
      rrhp_pkg::PH_ARR_PREFIX, rrhp_pkg::PH_CMD_PREFIX: begin
        prefix = (cur_phase == rrhp_pkg::PH_ARR_PREFIX) ?
                 rrhp_pkg::CHAR_STAR : rrhp_pkg::CHAR_DOLLAR;
        if (b != prefix) begin
          err_code  = (cur_phase == rrhp_pkg::PH_ARR_PREFIX) ?
                      rrhp_pkg::ERR_NO_STAR : rrhp_pkg::ERR_NO_DOLLAR;
          cur_phase = rrhp_pkg::PH_ERROR;
        end else begin
          reset_field();
          cur_phase = (cur_phase == rrhp_pkg::PH_ARR_PREFIX) ?
                      rrhp_pkg::PH_ARR_FIELD : rrhp_pkg::PH_CMD_FIELD;
          if (eom) begin
            err_code  = rrhp_pkg::ERR_NO_DELIM;
            cur_phase = rrhp_pkg::PH_ERROR;
          end
        end
      end
      rrhp_pkg::PH_ARR_FIELD, rrhp_pkg::PH_CMD_FIELD: begin
        if (fld_cr && b == rrhp_pkg::CHAR_LF) begin
          value = fld_neg ? (32'd0 - fld_mag) : fld_mag;
          if (fld_bad) begin
            err_code  = rrhp_pkg::ERR_BAD_NUM;
            cur_phase = rrhp_pkg::PH_ERROR;
          end else if (eom) begin
            err_code  = rrhp_pkg::ERR_END_DELIM;
            cur_phase = rrhp_pkg::PH_ERROR;
          end else if (cur_phase == rrhp_pkg::PH_ARR_FIELD) begin
            arr_len   = value;
            cur_phase = rrhp_pkg::PH_CMD_PREFIX;
          end else begin
            cmd_len   = value;
            cmd_sent  = 31'd0;
            cur_phase = rrhp_pkg::PH_COMMAND;
          end
          reset_field();
        end else begin
          field_byte(b);
          fld_cr = (b == rrhp_pkg::CHAR_CR);
          if (eom) begin
            err_code  = rrhp_pkg::ERR_NO_DELIM;
            cur_phase = rrhp_pkg::PH_ERROR;
          end
        end
      end
      rrhp_pkg::PH_COMMAND: begin
        // A negative length forwards nothing.
        if (!cmd_len[31] && {1'b0, cmd_sent} < cmd_len) begin
          cmd_sent    = cmd_sent + 31'd1;
          r           = '0;
          r.cbyte     = b;
          r.last      = !eom;
          due_results = {due_results, r};
        end
      end
      default: cur_phase = rrhp_pkg::PH_ERROR;
    endcase

    if (eom) begin
      r      = '0;
      r.kind = 1'b1;
      r.last = 1'b1;
      if (cur_phase == rrhp_pkg::PH_COMMAND) begin
        r.success = 1'b1;
        r.alen    = arr_len;
        r.clen    = cmd_len;
        r.taken   = cmd_sent;
      end else begin
        r.err = (err_code == rrhp_pkg::ERR_NONE) ? rrhp_pkg::ERR_NO_DELIM : err_code;
      end
      due_results = {due_results, r};
      reset_request();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Values are sampled at the edge, before any nonblocking update lands.
  always @(posedge clk) begin : monitor
    parse_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        $error("result beat arrived with nothing expected");
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(m_axis_tuser[0]));
        check_field("command_byte", 32'(want.cbyte), 32'(m_axis_tdata[7:0]));
        check_field("success", 32'(want.success), 32'(m_axis_tdata[8]));
        check_field("fault_code", 32'(want.err), 32'(m_axis_tdata[11:9]));
        check_field("array_length", want.alen, m_axis_tdata[43:12]);
        check_field("command_length", want.clen, m_axis_tdata[75:44]);
        check_field("command_bytes_received", 32'(want.taken),
                    32'(m_axis_tdata[106:76]));
        check_field("last", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  // The run is hung if no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("FAIL resp_request_header_parser");
      $finish;
    end
  end

  // Result side: before each beat, hold tready low for a randomly drawn stall.
  // When no stall is drawn, tready simply stays high.
  initial begin : sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Sends one byte after a random gap. tvalid is left high after the
  // handshake: the next call, in the same time step, either reuses it or
  // lowers it for its own gap, and await_results lowers it before any pause.
  task automatic send_byte(input logic [7:0] b, input logic eom);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eom;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    parse_request_byte(b, eom);
    bytes_sent++;
  endtask

  task automatic send_request();
    for (int i = 0; i < request_bytes.size(); i++)
      send_byte(request_bytes[i], i == request_bytes.size() - 1);
  endtask

  // Stops sending, waits until every owed beat has come, and then idles for
  // bytes that are still on their way through the parser.
  task automatic await_results();
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void append_byte(input logic [7:0] b);
    request_bytes = {request_bytes, b};
  endfunction

  // Appends text to the request; '|' stands for CR LF and '^' for a lone CR.
  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] == "|") begin
        append_byte(rrhp_pkg::CHAR_CR);
        append_byte(rrhp_pkg::CHAR_LF);
      end else if (s[i] == "^") begin
        append_byte(rrhp_pkg::CHAR_CR);
      end else begin
        append_byte(s[i]);
      end
    end
  endfunction

  task automatic send_text(input string s);
    request_bytes = {};
    add_text(s);
    send_request();
  endtask

  // Mostly small lengths, with a share at and just beyond the int range.
  function automatic longint pick_length();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return longint'($urandom_range(0, 99));
      5:       return 64'sd2147483647 - longint'($urandom_range(0, 2));
      6:       return -64'sd2147483648 + longint'($urandom_range(0, 2));
      7:       return longint'(int'($urandom));
      8:       return 64'sd2147483648 + longint'($urandom_range(0, 9999));
      default: return -64'sd2147483649 - longint'($urandom_range(0, 9999));
    endcase
  endfunction

  // Decimal text, sometimes with leading zeros.
  function automatic string length_text(input longint v);
    if ($urandom_range(0, 7) != 0)
      return $sformatf("%0d", v);
    if (v < 0)
      return {"-00", $sformatf("%0d", -v)};
    return {"00", $sformatf("%0d", v)};
  endfunction

  // Junk after the digits; the first byte is a letter so the number ends.
  function automatic void add_trail();
    append_byte(8'($urandom_range(8'h41, 8'h5A)));
    repeat ($urandom_range(0, 2)) append_byte(8'($urandom));
  endfunction

  function automatic void build_request();
    longint alen;
    longint clen;
    int     n;
    alen = pick_length();
    clen = ($urandom_range(0, 3) != 0) ? longint'($urandom_range(0, 10)) : pick_length();
    request_bytes = {};
    add_text({"*", length_text(alen)});
    if ($urandom_range(0, 5) == 0) add_trail();
    add_text("|");
    add_text({"$", length_text(clen)});
    if ($urandom_range(0, 5) == 0) add_trail();
    add_text("|");
    // Now and then the request ends right on the delimiter.
    n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
    repeat (n) append_byte(8'($urandom));
  endfunction

  // Cuts, overwrites or extends a well-formed request, or replaces it with
  // noise that sometimes still starts with the array prefix.
  function automatic void corrupt_request();
    int k;
    case ($urandom_range(0, 3))
      0: begin
        k = $urandom_range(1, request_bytes.size());
        while (request_bytes.size() > k) void'(request_bytes.pop_back());
      end
      1: request_bytes[$urandom_range(0, request_bytes.size() - 1)] = 8'($urandom);
      2: request_bytes.insert($urandom_range(0, request_bytes.size() - 1), 8'($urandom));
      default: begin
        request_bytes = {};
        if ($urandom_range(0, 1) != 0) append_byte(rrhp_pkg::CHAR_STAR);
        repeat ($urandom_range(1, 6)) append_byte(8'($urandom));
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-written requests: every verdict and the corners of the length fields.
  task automatic test_directed();
    send_text("*1|$4|PING");
    send_text("x");                          // wrong array prefix on the final byte
    send_text("*1|x$1|abc");                 // wrong command prefix, rest absorbed
    send_text("*");                          // ends on the array prefix
    send_text("*1|$");                       // ends on the command prefix
    send_text("*37");                        // ends inside the digits
    send_text("*2|");                        // ends on the array delimiter
    send_text("*1|$3|");                     // ends on the command delimiter
    send_text("*|$1|a");                     // no digits
    send_text("*-|$1|a");                    // sign only
    send_text("*2147483647|$-2147483648|ab");
    send_text("*-2147483648|$2147483647|q");
    send_text("*2147483648|$1|a");           // one past the positive limit
    send_text("*-2147483649|$1|a");          // one past the negative limit
    send_text("*99999999999|$1|a");
    send_text("*0012xy z|$-0|k");            // trailing junk and minus zero
    send_text("*5^7|$2^|ab");                // lone CR inside the field
    send_text("*1|$6|abc");                  // command cut short
    send_text("*1|$2|abcdef");               // bytes beyond the command
    send_text("*1|$0|z");
    send_text("*1|$-5|zz");
    request_bytes = {};
    add_text("*1|$2|");
    append_byte(8'h00);
    append_byte(8'hFF);
    send_request();
  endtask

  task automatic test_wellformed(input int budget);
    int stop;
    stop = bytes_sent + budget;
    while (bytes_sent < stop) begin
      build_request();
      send_request();
    end
  endtask

  // Same traffic with both sides running at full rate, so that neither side
  // idles.
  task automatic test_back_to_back(input int budget);
    steady = 1'b1;
    test_wellformed(budget);
    steady = 1'b0;
  endtask

  task automatic test_malformed(input int budget);
    int stop;
    stop = bytes_sent + budget;
    while (bytes_sent < stop) begin
      build_request();
      corrupt_request();
      send_request();
    end
  endtask

  initial begin
    reset_request();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    await_results();
    test_wellformed(450);
    await_results();
    test_back_to_back(120);
    test_malformed(230);
    await_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("%0d result beats never arrived", due_results.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("PASS resp_request_header_parser");
    else
      $display("FAIL resp_request_header_parser");
    $finish;
  end

endmodule
